// File: hw/rtl/fcs_pkg.sv
// fcs_pkg: shared types and constants for the filled circle span generator
// holds the transfer payload structs, register indexes and reset values
// used by fcs_map, fcs_walk and filled_circle_span_generator
package fcs_pkg;

    localparam int RADIUS_BITS_DEF = 10;
    localparam int PIXEL_BITS_DEF  = 16;
    localparam int FIELD_BITS      = 16;
    localparam int CFG_INDEX_BITS  = 2;
    localparam int CFG_DATA_BITS   = 32;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_X_GAIN   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_Y_GAIN   = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_X_OFFSET = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_Y_OFFSET = 2'd3;

    localparam logic [31:0] GAIN_RESET   = 32'h0001_0000;
    localparam logic [30:0] OFFSET_RESET = 31'h0000_8000;

    localparam logic ACT_START = 1'b0;

    localparam logic [1:0] SPAN_LAST   = 2'd3;
    localparam logic [1:0] START_FINAL = 2'd2;

    typedef struct packed {
        logic               action;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic        [9:0]  radius;
    } item_t;

    typedef struct packed {
        logic signed [FIELD_BITS-1:0] x_from;
        logic signed [FIELD_BITS-1:0] x_to;
        logic signed [FIELD_BITS-1:0] row;
        logic                         last_span;
    } span_t;

    typedef struct packed {
        logic       start;
        logic       advance;
        logic [1:0] span_idx;
    } walk_ctrl_t;

endpackage

// File: hw/rtl/fcs_map.sv
// fcs_map: world to pixel mapping of one axis, Q16.16 gain and offset
// multiply, offset add, then truncate toward zero and saturate (two register stages)
// depends on fcs_pkg
module fcs_map #(
    parameter int PIXEL_BITS = fcs_pkg::PIXEL_BITS_DEF
) (
    input  logic                         clk,
    input  logic signed [31:0]           coord,
    input  logic        [31:0]           gain,
    input  logic        [30:0]           offset,
    output logic signed [PIXEL_BITS-1:0] pixel
);
    import fcs_pkg::*;

    localparam logic signed [32:0] PIX_MAX = 33'(2 ** (PIXEL_BITS - 1) - 1);
    localparam logic signed [32:0] PIX_MIN = 33'(-(2 ** (PIXEL_BITS - 1)));

    logic signed [32:0] coord_ext;
    logic signed [32:0] gain_ext;
    logic signed [65:0] prod_full;
    logic signed [63:0] prod_next;
    logic signed [63:0] prod_reg;
    logic signed [64:0] sum_next;
    logic signed [64:0] sum_reg;
    logic signed [32:0] q_floor;
    logic signed [32:0] q_trunc;
    logic               frac_nz;

    assign coord_ext = {coord[31], coord};
    assign gain_ext  = {1'b0, gain};
    assign prod_full = coord_ext * gain_ext;
    assign prod_next = $signed(prod_full[63:0]);
    assign sum_next  = $signed({prod_reg[63], prod_reg}) + $signed({18'd0, offset, 16'd0});

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        sum_reg  <= sum_next;
    end

    // round toward zero: floor plus one when negative with a fraction
    assign q_floor = $signed(sum_reg[64:32]);
    assign frac_nz = |sum_reg[31:0];
    assign q_trunc = q_floor + $signed({32'd0, sum_reg[64] & frac_nz});

    always_comb
    begin
        if (q_trunc > PIX_MAX)
            pixel = PIX_MAX[PIXEL_BITS-1:0];
        else if (q_trunc < PIX_MIN)
            pixel = PIX_MIN[PIXEL_BITS-1:0];
        else
            pixel = q_trunc[PIXEL_BITS-1:0];
    end

endmodule

// File: hw/rtl/fcs_walk.sv
// fcs_walk: midpoint circle walk state, error recurrence and span ends
// one span per call from the span index, walk advances on the fourth
// depends on fcs_pkg
module fcs_walk #(
    parameter int RADIUS_BITS = fcs_pkg::RADIUS_BITS_DEF,
    parameter int PIXEL_BITS  = fcs_pkg::PIXEL_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  fcs_pkg::walk_ctrl_t          ctrl,
    input  logic signed [PIXEL_BITS-1:0] center_x,
    input  logic signed [PIXEL_BITS-1:0] center_y,
    input  logic        [9:0]            radius,
    output fcs_pkg::span_t               span,
    output logic                         active
);
    import fcs_pkg::*;

    localparam int XW = RADIUS_BITS + 2;
    localparam int DW = RADIUS_BITS + 3;
    localparam int EW = RADIUS_BITS + 4;
    localparam int SW = ((PIXEL_BITS > XW) ? PIXEL_BITS : XW) + 1;
    localparam logic signed [SW-1:0] PMAX = SW'(2 ** (PIXEL_BITS - 1) - 1);
    localparam logic signed [SW-1:0] PMIN = SW'(-(2 ** (PIXEL_BITS - 1)));

    function automatic logic signed [FIELD_BITS-1:0] sat_pix(input logic signed [SW-1:0] v);
        logic signed [PIXEL_BITS-1:0] r;
        if (v > PMAX)
            r = PMAX[PIXEL_BITS-1:0];
        else if (v < PMIN)
            r = PMIN[PIXEL_BITS-1:0];
        else
            r = v[PIXEL_BITS-1:0];
        return FIELD_BITS'(r);
    endfunction

    logic signed [PIXEL_BITS-1:0] cx_reg, cy_reg;
    logic        [RADIUS_BITS-1:0] rad_reg;
    logic signed [XW-1:0] wx_reg, wy_reg, wx_next, wy_next;
    logic signed [DW-1:0] dx_reg, dy_reg, dx_next, dy_next;
    logic signed [EW-1:0] err_reg, err_next, err_mid;
    logic                 active_reg;

    logic [RADIUS_BITS+9:0]  rad_wide;
    logic [RADIUS_BITS-1:0]  rad_in;
    logic signed [EW-1:0]    two_r;
    logic                    x_step;
    logic                    last;
    logic signed [XW-1:0]    u, v;
    logic signed [SW-1:0]    sp, sm, rp, rm;

    assign rad_wide = {{RADIUS_BITS{1'b0}}, radius};
    assign rad_in   = rad_wide[RADIUS_BITS-1:0];
    assign two_r    = $signed({3'b000, rad_reg, 1'b0});

    // error recurrence for one iteration
    always_comb
    begin
        if (err_reg <= 0)
        begin
            wy_next = wy_reg + XW'(1);
            err_mid = err_reg + EW'(dy_reg);
            dy_next = dy_reg + DW'(2);
        end
        else
        begin
            wy_next = wy_reg;
            err_mid = err_reg;
            dy_next = dy_reg;
        end
        x_step = err_mid > 0;
        if (x_step)
        begin
            wx_next  = wx_reg - XW'(1);
            dx_next  = dx_reg + DW'(2);
            err_next = err_mid + EW'(dx_next) - two_r;
        end
        else
        begin
            wx_next  = wx_reg;
            dx_next  = dx_reg;
            err_next = err_mid;
        end
    end

    assign last = wx_next < wy_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg     <= '0;
            cy_reg     <= '0;
            rad_reg    <= '0;
            wx_reg     <= '0;
            wy_reg     <= '0;
            dx_reg     <= '0;
            dy_reg     <= '0;
            err_reg    <= '0;
            active_reg <= 1'b0;
        end
        else if (ctrl.start)
        begin
            cx_reg     <= center_x;
            cy_reg     <= center_y;
            rad_reg    <= rad_in;
            wx_reg     <= $signed({2'b00, rad_in});
            wy_reg     <= '0;
            dx_reg     <= DW'(1);
            dy_reg     <= DW'(1);
            err_reg    <= EW'(3) - $signed({3'b000, rad_in, 1'b0});
            active_reg <= 1'b1;
        end
        else if (ctrl.advance)
        begin
            wx_reg     <= wx_next;
            wy_reg     <= wy_next;
            dx_reg     <= dx_next;
            dy_reg     <= dy_next;
            err_reg    <= err_next;
            active_reg <= !last;
        end
    end

    // odd spans swap the roles of x and y, upper two mirror the ends and row
    assign u  = ctrl.span_idx[0] ? wy_reg : wx_reg;
    assign v  = ctrl.span_idx[0] ? wx_reg : wy_reg;
    assign sp = SW'(cx_reg) + SW'(u);
    assign sm = SW'(cx_reg) - SW'(u);
    assign rp = SW'(cy_reg) + SW'(v);
    assign rm = SW'(cy_reg) - SW'(v);

    always_comb
    begin
        if (ctrl.span_idx[1])
        begin
            span.x_from = sat_pix(sm);
            span.x_to   = sat_pix(sp);
            span.row    = sat_pix(rm);
        end
        else
        begin
            span.x_from = sat_pix(sp);
            span.x_to   = sat_pix(sm);
            span.row    = sat_pix(rp);
        end
        span.last_span = (ctrl.span_idx == SPAN_LAST) && last;
    end

    assign active = active_reg;

endmodule

// File: hw/rtl/filled_circle_span_generator.sv
// filled_circle_span_generator: filled circle rasterizer, four spans per step
// top level with item register, config registers and span output register
// depends on fcs_pkg, fcs_map, fcs_walk
//
//   channel  signals                               transfer when
//   item     item_valid, item_stall, item          item_valid && !item_stall
//   span     span_valid, span_stall, span          span_valid && !span_stall
//   cfg      cfg_valid, cfg_ready, cfg_index/data  cfg_valid && cfg_ready
//
// a step item loads four spans, one span per cycle into the output register while the span output does not stall
// a start item goes through multiply, offset add, then truncate and saturate
// a step item while idle is dropped and gives nothing
// reset clears the walk to idle and loads the register defaults
// a stalled span output holds the walk; the item side stalls until done
module filled_circle_span_generator #(
    parameter int RADIUS_BITS = fcs_pkg::RADIUS_BITS_DEF,
    parameter int PIXEL_BITS  = fcs_pkg::PIXEL_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  fcs_pkg::item_t                       item,
    output logic                                 span_valid,
    input  logic                                 span_stall,
    output fcs_pkg::span_t                       span,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [fcs_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [fcs_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
    import fcs_pkg::*;

    logic [31:0] x_gain_reg, y_gain_reg;
    logic [30:0] x_offset_reg, y_offset_reg;

    item_t      item_reg;
    logic       item_valid_reg;
    logic [1:0] phase_reg, phase_next;
    span_t      span_reg, span_next;
    logic       span_valid_reg;

    logic       is_start;
    logic       walk_active;
    logic       span_load;
    logic       start_commit;
    logic       drop;
    logic       item_done;
    logic       item_take;
    walk_ctrl_t walk_ctrl;

    logic signed [PIXEL_BITS-1:0] pix_x, pix_y;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_gain_reg   <= GAIN_RESET;
            y_gain_reg   <= GAIN_RESET;
            x_offset_reg <= OFFSET_RESET;
            y_offset_reg <= OFFSET_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_X_GAIN:   x_gain_reg   <= cfg_data;
                CFG_Y_GAIN:   y_gain_reg   <= cfg_data;
                CFG_X_OFFSET: x_offset_reg <= cfg_data[30:0];
                CFG_Y_OFFSET: y_offset_reg <= cfg_data[30:0];
                default:      x_gain_reg   <= x_gain_reg;
            endcase
        end
    end

    assign is_start     = item_reg.action == ACT_START;
    assign span_load    = item_valid_reg && !is_start && walk_active
                          && (!span_valid_reg || !span_stall);
    assign start_commit = item_valid_reg && is_start && (phase_reg == START_FINAL);
    assign drop         = item_valid_reg && !is_start && !walk_active;
    assign item_done    = start_commit || drop || (span_load && (phase_reg == SPAN_LAST));
    assign item_stall   = item_valid_reg && !item_done;
    assign item_take    = item_valid && !item_stall;

    always_comb
    begin
        if (item_take || item_done)
            phase_next = '0;
        else if ((item_valid_reg && is_start) || span_load)
            phase_next = phase_reg + 2'd1;
        else
            phase_next = phase_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            phase_reg      <= '0;
            span_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (item_take)
                item_valid_reg <= 1'b1;
            else if (item_done)
                item_valid_reg <= 1'b0;
            if (span_load)
                span_valid_reg <= 1'b1;
            else if (!span_stall)
                span_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
            item_reg <= item;
        if (span_load)
            span_reg <= span_next;
    end

    fcs_map #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_map_x (
        .clk    (clk),
        .coord  (item_reg.center_x),
        .gain   (x_gain_reg),
        .offset (x_offset_reg),
        .pixel  (pix_x)
    );

    fcs_map #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_map_y (
        .clk    (clk),
        .coord  (item_reg.center_y),
        .gain   (y_gain_reg),
        .offset (y_offset_reg),
        .pixel  (pix_y)
    );

    assign walk_ctrl.start    = start_commit;
    assign walk_ctrl.advance  = span_load && (phase_reg == SPAN_LAST);
    assign walk_ctrl.span_idx = phase_reg;

    fcs_walk #(
        .RADIUS_BITS (RADIUS_BITS),
        .PIXEL_BITS  (PIXEL_BITS)
    ) u_walk (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (walk_ctrl),
        .center_x (pix_x),
        .center_y (pix_y),
        .radius   (item_reg.radius),
        .span     (span_next),
        .active   (walk_active)
    );

    assign span_valid = span_valid_reg;
    assign span       = span_reg;

    a_last_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (span_load && span_next.last_span) |=> !walk_active)
        else $error("walk still active after last span");

    a_last_on_fourth: assert property (@(posedge clk) disable iff (!rst_n)
        (span_load && span_next.last_span) |-> (phase_reg == SPAN_LAST))
        else $error("last span marked outside the fourth span");

    a_start_arms_walk: assert property (@(posedge clk) disable iff (!rst_n)
        start_commit |=> walk_active)
        else $error("start did not arm the walk");

    a_no_span_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && is_start) |-> !span_load)
        else $error("span loaded while a start item is in progress");

endmodule

// File: tb/sv/filled_circle_span_generator_tb.sv
// filled_circle_span_generator_tb: self-checking bench for the filled circle span generator
// directed table then random circles over several register settings, with random stalls
// depends on fcs_pkg and filled_circle_span_generator
module filled_circle_span_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fcs_pkg::*;

    localparam logic ACT_STEP = ~ACT_START;
    localparam int PIX_MAX = 2 ** (PIXEL_BITS_DEF - 1) - 1;
    localparam int PIX_MIN = -PIX_MAX - 1;
    localparam int QUIET_LIMIT = 1000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic        action;
        logic [31:0] cx;
        logic [31:0] cy;
        logic [9:0]  radius;
        logic        typed;
        logic [2:0]  n_want;
        logic [15:0] want_x;
        logic [15:0] want_row;
    } plan_row_t;

    localparam plan_row_t DIRECTED_PLAN [24] = '{
        '{ACT_STEP,  32'h0000_0000, 32'h0000_0000, 10'd0,   1'b1, 3'd0, 16'h0000, 16'h0000},
        '{ACT_START, 32'h0000_0000, 32'h0000_0000, 10'd0,   1'b1, 3'd0, 16'h0000, 16'h0000},
        '{ACT_STEP,  32'h0000_0000, 32'h0000_0000, 10'd0,   1'b1, 3'd4, 16'h0000, 16'h0000},
        '{ACT_STEP,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'h3FF, 1'b1, 3'd0, 16'h0000, 16'h0000},
        '{ACT_START, 32'h7FFF_FFFF, 32'h8000_0000, 10'd0,   1'b1, 3'd0, 16'h0000, 16'h0000},
        '{ACT_STEP,  32'h0000_0000, 32'h0000_0000, 10'd0,   1'b1, 3'd4, 16'h7FFF, 16'h8001},
        '{ACT_START, 32'h7FFF_FFFF, 32'h8000_0000, 10'h3FF, 1'b0, 3'd0, 16'h0000, 16'h0000},
        '{ACT_STEP,  32'h0000_0000, 32'h0000_0000, 10'd0,   1'b0, 3'd0, 16'h0000, 16'h0000},
        '{ACT_STEP,  32'h0000_0000, 32'h0000_0000, 10'd0,   1'b0, 3'd0, 16'h0000, 16'h0000},
        '{ACT_STEP,  32'h0000_0000, 32'h0000_0000, 10'd0,   1'b0, 3'd0, 16'h0000, 16'h0000},
        '{ACT_START, 32'h0000_0000, 32'h0000_0000, 10'd1,   1'b0, 3'd0, 16'h0000, 16'h0000},
        '{ACT_STEP,  32'h0000_0000, 32'h0000_0000, 10'd0,   1'b0, 3'd0, 16'h0000, 16'h0000},
        '{ACT_STEP,  32'h0000_0000, 32'h0000_0000, 10'd0,   1'b0, 3'd0, 16'h0000, 16'h0000},
        '{ACT_STEP,  32'h0000_0000, 32'h0000_0000, 10'd0,   1'b0, 3'd0, 16'h0000, 16'h0000},
        '{ACT_START, 32'hFFFF_FFFF, 32'h0001_0000, 10'd2,   1'b0, 3'd0, 16'h0000, 16'h0000},
        '{ACT_STEP,  32'h0000_0000, 32'h0000_0000, 10'd0,   1'b0, 3'd0, 16'h0000, 16'h0000},
        '{ACT_STEP,  32'h0000_0000, 32'h0000_0000, 10'd0,   1'b0, 3'd0, 16'h0000, 16'h0000},
        '{ACT_STEP,  32'h0000_0000, 32'h0000_0000, 10'd0,   1'b0, 3'd0, 16'h0000, 16'h0000},
        '{ACT_START, 32'h8000_0000, 32'h7FFF_FFFF, 10'd7,   1'b0, 3'd0, 16'h0000, 16'h0000},
        '{ACT_STEP,  32'h0000_0000, 32'h0000_0000, 10'd0,   1'b0, 3'd0, 16'h0000, 16'h0000},
        '{ACT_STEP,  32'h0000_0000, 32'h0000_0000, 10'd0,   1'b0, 3'd0, 16'h0000, 16'h0000},
        '{ACT_START, 32'h1234_5678, 32'h8765_4321, 10'h155, 1'b0, 3'd0, 16'h0000, 16'h0000},
        '{ACT_STEP,  32'h0000_0000, 32'h0000_0000, 10'd0,   1'b0, 3'd0, 16'h0000, 16'h0000},
        '{ACT_START, 32'hEDCB_A987, 32'h789A_BCDE, 10'h2AA, 1'b0, 3'd0, 16'h0000, 16'h0000}
    };

    logic clk;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_stall;
    item_t item = '0;
    logic span_valid;
    logic span_stall = 1'b0;
    span_t span;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    // typed expectation that travels with the item being offered
    logic row_typed = 1'b0;
    logic [2:0] row_count = '0;
    logic [15:0] row_x = '0;
    logic [15:0] row_row = '0;

    // predictor state
    logic [31:0] gain_x = GAIN_RESET;
    logic [31:0] gain_y = GAIN_RESET;
    logic [30:0] off_x = OFFSET_RESET;
    logic [30:0] off_y = OFFSET_RESET;
    int ctr_px = 0;
    int ctr_py = 0;
    int rad_q = 0;
    int arc_x = 0;
    int arc_y = 0;
    int inc_x = 0;
    int inc_y = 0;
    int bend = 0;
    bit drawing = 1'b0;

    span_t expected_spans[$];
    int mismatches = 0;
    int items_seen = 0;
    int useful_items = 0;
    int spans_checked = 0;
    int circles_done = 0;
    int quiet_cycles = 0;
    int stall_left = 0;
    bit calm = 1'b0;

    filled_circle_span_generator dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .span_valid (span_valid),
        .span_stall (span_stall),
        .span       (span),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int clip_pixel(input longint v);
        if (v > PIX_MAX)
            return PIX_MAX;
        if (v < PIX_MIN)
            return PIX_MIN;
        return int'(v);
    endfunction

    // Q16.16 world coordinate to pixel, truncated toward zero and clipped to the pixel range
    function automatic int to_pixel(input logic signed [31:0] c, input logic [31:0] gain,
                                    input logic [30:0] off);
        longint prod;
        longint sum;
        longint lim;
        longint q;
        lim = longint'(1) << 49;
        prod = longint'(c) * longint'({32'd0, gain});
        if (prod > lim)
            prod = lim;
        if (prod < -lim)
            prod = -lim;
        sum = prod + (longint'({33'd0, off}) << 16);
        if (sum >= 0)
            q = sum >>> 32;
        else
            q = -((-sum) >>> 32);
        return clip_pixel(q);
    endfunction

    function automatic span_t make_span(input int a, input int b, input int r, input bit fin);
        span_t s;
        s.x_from = 16'(clip_pixel(a));
        s.x_to = 16'(clip_pixel(b));
        s.row = 16'(clip_pixel(r));
        s.last_span = fin;
        return s;
    endfunction

    function automatic void raster_item(input item_t it, output span_t got[4], output int count);
        int x0;
        int y0;
        int cx;
        int cy;
        bit fin;
        count = 0;
        if (it.action == ACT_START)
        begin
            ctr_px = to_pixel(it.center_x, gain_x, off_x);
            ctr_py = to_pixel(it.center_y, gain_y, off_y);
            rad_q = int'(it.radius);
            arc_x = rad_q;
            arc_y = 0;
            inc_x = 1;
            inc_y = 1;
            bend = 1 - 2 * (rad_q - 1);
            drawing = 1'b1;
            return;
        end
        if (!drawing)
            return;
        x0 = ctr_px;
        y0 = ctr_py;
        cx = arc_x;
        cy = arc_y;
        if (bend <= 0)
        begin
            arc_y += 1;
            bend += inc_y;
            inc_y += 2;
        end
        if (bend > 0)
        begin
            arc_x -= 1;
            inc_x += 2;
            bend += inc_x - 2 * rad_q;
        end
        fin = arc_x < arc_y;
        if (fin)
            drawing = 1'b0;
        got[0] = make_span(x0 + cx, x0 - cx, y0 + cy, 1'b0);
        got[1] = make_span(x0 + cy, x0 - cy, y0 + cx, 1'b0);
        got[2] = make_span(x0 - cx, x0 + cx, y0 - cy, 1'b0);
        got[3] = make_span(x0 - cy, x0 + cy, y0 - cx, fin);
        count = 4;
    endfunction

    task automatic note_mismatch(input string msg);
        if (mismatches < 50)
            $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // monitor: register writes, item transfers and span transfers
    always @(posedge clk)
    begin
        span_t got[4];
        span_t want;
        int n;
        bit moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                moved = 1'b1;
                case (cfg_index)
                    CFG_X_GAIN:   gain_x = cfg_data;
                    CFG_Y_GAIN:   gain_y = cfg_data;
                    CFG_X_OFFSET: off_x = cfg_data[30:0];
                    CFG_Y_OFFSET: off_y = cfg_data[30:0];
                    default: ;
                endcase
            end
            if (item_valid && !item_stall)
            begin
                moved = 1'b1;
                items_seen++;
                raster_item(item, got, n);
                if (item.action == ACT_START || n > 0)
                    useful_items++;
                if (row_typed)
                begin
                    for (int k = 0; k < int'(row_count); k++)
                    begin
                        want.x_from = row_x;
                        want.x_to = row_x;
                        want.row = row_row;
                        want.last_span = (k == 3);
                        expected_spans.push_back(want);
                    end
                end
                else
                begin
                    for (int k = 0; k < n; k++)
                        expected_spans.push_back(got[k]);
                end
            end
            if (span_valid && !span_stall)
            begin
                moved = 1'b1;
                if (expected_spans.size() == 0)
                begin
                    note_mismatch($sformatf("unexpected span %0d..%0d row %0d last %0b",
                        span.x_from, span.x_to, span.row, span.last_span));
                end
                else
                begin
                    want = expected_spans.pop_front();
                    spans_checked++;
                    if (want.last_span)
                        circles_done++;
                    if (span.x_from !== want.x_from)
                        note_mismatch($sformatf("x_from %0d, want %0d", span.x_from, want.x_from));
                    if (span.x_to !== want.x_to)
                        note_mismatch($sformatf("x_to %0d, want %0d", span.x_to, want.x_to));
                    if (span.row !== want.row)
                        note_mismatch($sformatf("row %0d, want %0d", span.row, want.row));
                    if (span.last_span !== want.last_span)
                        note_mismatch($sformatf("last_span %0b, want %0b",
                            span.last_span, want.last_span));
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // span receiver stalls at random, sometimes in bursts, and never in reset or the calm phase
    always @(negedge clk)
    begin
        if (!rst_n || calm)
        begin
            span_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            span_stall <= 1'b1;
            stall_left--;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            span_stall <= 1'b1;
            stall_left = $urandom_range(0, 2);
        end
        else
        begin
            span_stall <= 1'b0;
        end
    end

    task automatic drive_item(input item_t it, input logic typed, input logic [2:0] n_want,
                              input logic [15:0] wx, input logic [15:0] wr);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        item <= it;
        row_typed <= typed;
        row_count <= n_want;
        row_x <= wx;
        row_row <= wr;
        item_valid <= 1'b1;
        do @(posedge clk); while (!(item_valid && !item_stall));
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [31:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        @(negedge clk);
    endtask

    task automatic drain_idle();
        item_valid <= 1'b0;
        while (expected_spans.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic int pick_coord();
        case ($urandom_range(0, 2))
            0: return $urandom;
            1: return $urandom_range(0, 800 << 16) - (400 << 16);
            default: return $urandom_range(0, 2 << 16) - (1 << 16);
        endcase
    endfunction

    function automatic logic [9:0] pick_radius();
        case ($urandom_range(0, 19))
            0: return 10'($urandom_range(0, 1023));
            1, 2, 3: return 10'($urandom_range(25, 100));
            default: return 10'($urandom_range(0, 24));
        endcase
    endfunction

    // mostly whole circles with random centers, some cut short, some noise
    task automatic run_phase(input int target);
        item_t it;
        logic [95:0] noise;
        int steps;
        while (useful_items < target)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                noise = {$urandom, $urandom, $urandom};
                it = noise[$bits(item_t)-1:0];
                drive_item(it, 1'b0, 3'd0, 16'd0, 16'd0);
            end
            else
            begin
                it.action = ACT_START;
                it.center_x = pick_coord();
                it.center_y = pick_coord();
                it.radius = pick_radius();
                drive_item(it, 1'b0, 3'd0, 16'd0, 16'd0);
                if (it.radius > 100 || $urandom_range(0, 5) == 0)
                    steps = $urandom_range(1, 6);
                else
                    steps = int'(it.radius) * 3 / 4 + 2;
                repeat (steps)
                begin
                    noise = {$urandom, $urandom, $urandom};
                    it = noise[$bits(item_t)-1:0];
                    it.action = ACT_STEP;
                    drive_item(it, 1'b0, 3'd0, 16'd0, 16'd0);
                end
            end
        end
    endtask

    initial
    begin
        item_t it;
        logic [31:0] gx;
        logic [31:0] gy;
        logic [31:0] ox;
        logic [31:0] oy;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        foreach (DIRECTED_PLAN[i])
        begin
            it.action = DIRECTED_PLAN[i].action;
            it.center_x = DIRECTED_PLAN[i].cx;
            it.center_y = DIRECTED_PLAN[i].cy;
            it.radius = DIRECTED_PLAN[i].radius;
            drive_item(it, DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].n_want,
                       DIRECTED_PLAN[i].want_x, DIRECTED_PLAN[i].want_row);
        end
        run_phase(90);
        for (int p = 1; p <= 5; p++)
        begin
            drain_idle();
            if (p == 5)
                calm = 1'b1;
            case (p)
                1:
                begin
                    gx = '1; gy = '1; ox = '1; oy = '1;
                end
                2:
                begin
                    gx = '0; gy = '0; ox = '0; oy = '0;
                end
                3:
                begin
                    gx = $urandom; gy = $urandom; ox = $urandom; oy = $urandom;
                end
                4:
                begin
                    gx = $urandom_range(32'h8000, 32'h40000);
                    gy = $urandom_range(32'h8000, 32'h40000);
                    ox = $urandom_range(0, 1024 << 16);
                    oy = $urandom_range(0, 1024 << 16);
                end
                default:
                begin
                    gx = GAIN_RESET; gy = GAIN_RESET;
                    ox = {1'b0, OFFSET_RESET}; oy = {1'b0, OFFSET_RESET};
                end
            endcase
            write_reg(CFG_X_GAIN, gx);
            write_reg(CFG_Y_GAIN, gy);
            write_reg(CFG_X_OFFSET, ox);
            write_reg(CFG_Y_OFFSET, oy);
            cfg_valid <= 1'b0;
            run_phase(90 + p * 85);
        end
        drain_idle();
        $display("run covered %0d item transfers (%0d starting or advancing a circle), %0d spans",
                 items_seen, useful_items, spans_checked);
        $display("%0d circles finished, six register settings from zero to full scale",
                 circles_done);
        if (mismatches == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
